/* sv/phbm_pkg.sv */
// Shared constants, codes and mapping functions for the peak-hold bar meter.
`timescale 1ns / 1ps

package phbm_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int HOLD_W       = 8;
    localparam int LIT_W        = 4;
    localparam int BAR_SEGMENTS = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAW_OFFSET   = 2'd1;

    localparam logic [HOLD_W-1:0]   HOLD_SAMPLES_RESET = 8'd100;
    localparam logic [SAMPLE_W-1:0] RAW_OFFSET_RESET   = 10'd523;

    localparam int RAW_STEP = 50;

    localparam logic [SAMPLE_W-1:0] LADDER [BAR_SEGMENTS] = '{
        10'd615, 10'd680, 10'd721, 10'd753, 10'd777,
        10'd811, 10'd835, 10'd853, 10'd873, 10'd888
    };

    // Number of ladder thresholds reached or passed by the value.
    function automatic logic [LIT_W-1:0] ladder_level(input logic [SAMPLE_W-1:0] v);
        logic [LIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < BAR_SEGMENTS; i++) begin
            if (v >= LADDER[i]) begin
                n = LIT_W'(i + 1);
            end
        end
        return n;
    endfunction

    // Quotient by the raw step, clamped to the segment count.
    function automatic logic [LIT_W-1:0] raw_level(input logic [SAMPLE_W-1:0] d);
        logic [LIT_W-1:0] n;
        n = '0;
        for (int i = 0; i < BAR_SEGMENTS; i++) begin
            if (d >= SAMPLE_W'(RAW_STEP * (i + 1))) begin
                n = LIT_W'(i + 1);
            end
        end
        return n;
    endfunction

    // Thermometer code: bit i set when i is below the count.
    function automatic logic [BAR_SEGMENTS-1:0] thermometer(input logic [LIT_W-1:0] n);
        logic [BAR_SEGMENTS-1:0] p;
        for (int i = 0; i < BAR_SEGMENTS; i++) begin
            p[i] = (LIT_W'(i) < n);
        end
        return p;
    endfunction

endpackage

/* sv/phbm_peak_track.sv */
// Peak value and hold countdown, updated once per item.
`timescale 1ns / 1ps

module phbm_peak_track
    import phbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [HOLD_W-1:0]   hold_samples,
    output logic [SAMPLE_W-1:0] peak_next
);

    logic [SAMPLE_W-1:0] peak_value_reg;
    logic [HOLD_W-1:0]   hold_left_reg;
    logic [HOLD_W-1:0]   hold_left_next;
    logic [SAMPLE_W-1:0] peak_cand;
    logic [HOLD_W-1:0]   hold_cand;
    logic                new_peak;

    always_comb
    begin
        new_peak  = (sample > peak_value_reg);
        peak_cand = new_peak ? sample : peak_value_reg;
        hold_cand = new_peak ? hold_samples : hold_left_reg;
        if (hold_cand != '0)
        begin
            hold_left_next = hold_cand - HOLD_W'(1);
            peak_next      = peak_cand;
        end
        else
        begin
            // hold expired: follow the input
            hold_left_next = '0;
            peak_next      = sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_value_reg <= '0;
            hold_left_reg  <= '0;
        end
        else if (advance)
        begin
            peak_value_reg <= peak_next;
            hold_left_reg  <= hold_left_next;
        end
    end

endmodule

/* sv/phbm_bar_map.sv */
// Maps the peak or the offset sample to a lit segment count and bar pattern.
`timescale 1ns / 1ps

module phbm_bar_map
    import phbm_pkg::*;
(
    input  logic                    level_mode,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic [SAMPLE_W-1:0]     peak,
    input  logic [SAMPLE_W-1:0]     raw_offset,
    output logic [LIT_W-1:0]        lit_count,
    output logic [BAR_SEGMENTS-1:0] bar_pattern
);

    logic [SAMPLE_W-1:0] raw_diff;

    always_comb
    begin
        raw_diff = sample - raw_offset;
        if (level_mode)
        begin
            lit_count = ladder_level(peak);
        end
        else if (sample < raw_offset)
        begin
            lit_count = '0;
        end
        else
        begin
            lit_count = raw_level(raw_diff);
        end
        bar_pattern = thermometer(lit_count);
    end

endmodule

/* sv/peak_hold_level_bar_meter_unit.sv */
// Top level of the peak-hold bar meter: handshakes, registers and result stage.
`timescale 1ns / 1ps

// Peak-hold bar meter. Each item carries one 10-bit sample and a mode bit and
// yields exactly one result: the lit segment count (0..10), its thermometer
// pattern and the held peak after the update. A sample above the held peak
// becomes the new peak and reloads the hold countdown from hold_samples; the
// countdown then drops by one, and once it is zero the peak follows the
// sample. Level mode maps the peak through a fixed ladder of ten thresholds;
// raw mode gives (sample - raw_offset) / 50, zero below the offset, clamped
// to ten. Throughput is one item per clock while results are taken. An accepted
// item waits in the input register while the peak/hold update and the bar
// mapping run, and the result register captures it once it is free, which
// also closes the peak/hold feedback loop.
// A stalled result holds in the result register while one more item waits in
// the input register. The configuration port always accepts; write it only
// while no item is in flight. Register 0 is hold_samples (reset 100),
// register 1 is raw_offset (reset 523); other indexes are ignored.
module peak_hold_level_bar_meter_unit
    import phbm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic                    level_mode,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LIT_W-1:0]        lit_count,
    output logic [BAR_SEGMENTS-1:0] bar_pattern,
    output logic [SAMPLE_W-1:0]     held_peak,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [HOLD_W-1:0]       hold_samples_reg;
    logic [SAMPLE_W-1:0]     raw_offset_reg;

    logic                    s1_valid_reg;
    logic [SAMPLE_W-1:0]     s1_sample_reg;
    logic                    s1_level_reg;

    logic                    out_valid_reg;
    logic [LIT_W-1:0]        lit_count_reg;
    logic [BAR_SEGMENTS-1:0] bar_pattern_reg;
    logic [SAMPLE_W-1:0]     held_peak_reg;

    logic                    advance;
    logic                    step;
    logic                    in_take;
    logic [SAMPLE_W-1:0]     peak_next;
    logic [LIT_W-1:0]        lit_next;
    logic [BAR_SEGMENTS-1:0] pattern_next;

    // Result stage moves when it is empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    // An item leaves the input register into the result register.
    assign step     = advance && s1_valid_reg;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    // Configuration registers: drop writes to unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_samples_reg <= HOLD_SAMPLES_RESET;
            raw_offset_reg   <= RAW_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HOLD_SAMPLES: hold_samples_reg <= cfg_data[HOLD_W-1:0];
                CFG_RAW_OFFSET:   raw_offset_reg   <= cfg_data[SAMPLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register: hold the accepted item until the result stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= sample;
            s1_level_reg  <= level_mode;
        end
    end

    // Advance the peak and hold state only when an item enters the result stage.
    phbm_peak_track u_peak_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (step),
        .sample       (s1_sample_reg),
        .hold_samples (hold_samples_reg),
        .peak_next    (peak_next)
    );

    phbm_bar_map u_bar_map (
        .level_mode  (s1_level_reg),
        .sample      (s1_sample_reg),
        .peak        (peak_next),
        .raw_offset  (raw_offset_reg),
        .lit_count   (lit_next),
        .bar_pattern (pattern_next)
    );

    // Result register: hold the finished item until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            lit_count_reg   <= lit_next;
            bar_pattern_reg <= pattern_next;
            held_peak_reg   <= peak_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign lit_count   = lit_count_reg;
    assign bar_pattern = bar_pattern_reg;
    assign held_peak   = held_peak_reg;

    // Never more lit segments than the bar has.
    a_lit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lit_count <= LIT_W'(BAR_SEGMENTS)))
        else $error("lit count beyond segment count");

    // Pattern carries as many set bits as the count says.
    a_pattern_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(bar_pattern) == int'(lit_count)))
        else $error("bar pattern does not match lit count");

    // Pattern is a thermometer code: no gaps.
    a_pattern_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((bar_pattern & (bar_pattern + BAR_SEGMENTS'(1))) == '0))
        else $error("bar pattern is not a thermometer code");

    // Input stalls only when both stages are full and the result is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // A blocked result keeps its stage full in the next cycle.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(held_peak_reg)))
        else $error("blocked result lost");

endmodule

/* test/peak_hold_meter_checker.sv */
// Checker for the peak-hold bar meter: predicts each reading and compares it.
`timescale 1ns / 1ps

module peak_hold_meter_checker
    import phbm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [SAMPLE_W-1:0]     sample,
    input  logic                    level_mode,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [LIT_W-1:0]        lit_count,
    input  logic [BAR_SEGMENTS-1:0] bar_pattern,
    input  logic [SAMPLE_W-1:0]     held_peak,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      error_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [LIT_W-1:0]        lit;
        logic [BAR_SEGMENTS-1:0] bars;
        logic [SAMPLE_W-1:0]     peak;
    } meter_reading_t;

    localparam logic [SAMPLE_W-1:0] THRESHOLDS [10] = '{
        10'd615, 10'd680, 10'd721, 10'd753, 10'd777,
        10'd811, 10'd835, 10'd853, 10'd873, 10'd888
    };
    localparam int SEGMENT_STEP = 50;

    logic [SAMPLE_W-1:0] peak_track;
    logic [HOLD_W-1:0]   hold_count;
    logic [HOLD_W-1:0]   hold_setting;
    logic [SAMPLE_W-1:0] offset_setting;
    meter_reading_t      readings_due [$];
    int                  fail_total;

    assign error_count = fail_total;

    // Advance the peak/hold state by one sample and return the reading it gives.
    function automatic meter_reading_t predict_reading(input logic [SAMPLE_W-1:0] s,
                                                       input logic lvl);
        meter_reading_t r;
        int             lit;
        if (s > peak_track) begin
            peak_track = s;
            hold_count = hold_setting;
        end
        if (hold_count != '0) begin
            hold_count = hold_count - 1'b1;
        end
        else begin
            peak_track = s;
        end
        lit = 0;
        if (lvl) begin
            for (int i = 0; i < 10; i++) begin
                if (peak_track >= THRESHOLDS[i]) begin
                    lit = i + 1;
                end
            end
        end
        else if (s >= offset_setting) begin
            lit = (int'(s) - int'(offset_setting)) / SEGMENT_STEP;
            if (lit > BAR_SEGMENTS) begin
                lit = BAR_SEGMENTS;
            end
        end
        r.lit  = LIT_W'(lit);
        r.bars = BAR_SEGMENTS'((1 << lit) - 1);
        r.peak = peak_track;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        meter_reading_t want;
        if (!rst_n) begin
            peak_track     = '0;
            hold_count     = '0;
            hold_setting   = HOLD_SAMPLES_RESET;
            offset_setting = RAW_OFFSET_RESET;
            readings_due.delete();
            fail_total     = 0;
            outstanding   <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HOLD_SAMPLES: hold_setting   = cfg_data[HOLD_W-1:0];
                    CFG_RAW_OFFSET:   offset_setting = cfg_data[SAMPLE_W-1:0];
                    default:          ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: unexpected reading lit %0d bars %b peak %0d",
                             $time, lit_count, bar_pattern, held_peak);
                    fail_total++;
                end
                else begin
                    want = readings_due.pop_front();
                    if (lit_count !== want.lit) begin
                        $display("%0t: lit_count expected %0d, got %0d",
                                 $time, want.lit, lit_count);
                        fail_total++;
                    end
                    if (bar_pattern !== want.bars) begin
                        $display("%0t: bar_pattern expected %b, got %b",
                                 $time, want.bars, bar_pattern);
                        fail_total++;
                    end
                    if (held_peak !== want.peak) begin
                        $display("%0t: held_peak expected %0d, got %0d",
                                 $time, want.peak, held_peak);
                        fail_total++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                readings_due.push_back(predict_reading(sample, level_mode));
            end
            outstanding <= readings_due.size();
        end
    end

endmodule

/* test/peak_hold_level_bar_meter_unit_test.sv */
// Top of the peak-hold bar meter test: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module peak_hold_level_bar_meter_unit_test;
    import phbm_pkg::*;

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    // Cycles with no handshake at all before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_W-1:0]     sample      = '0;
    logic                    level_mode  = 1'b0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [LIT_W-1:0]        lit_count;
    logic [BAR_SEGMENTS-1:0] bar_pattern;
    logic [SAMPLE_W-1:0]     held_peak;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;

    int meter_errors;
    int readings_pending;

    // Stimulus bookkeeping: burst length left, current offset, last sample sent.
    int                  burst_left  = 0;
    int                  cur_offset  = RAW_OFFSET_RESET;
    int                  prev_sample = 0;

    // Receiver behaviour: a mode held for a random span of cycles.
    int                  stall_mode  = 0;
    int                  stall_span  = 0;
    int                  idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    peak_hold_level_bar_meter_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .level_mode  (level_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lit_count   (lit_count),
        .bar_pattern (bar_pattern),
        .held_peak   (held_peak),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    peak_hold_meter_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .level_mode  (level_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lit_count   (lit_count),
        .bar_pattern (bar_pattern),
        .held_peak   (held_peak),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (meter_errors),
        .outstanding (readings_pending)
    );

    // Receiver: every so often pick a new mode - always ready, mostly ready,
    // coin toss, or mostly stalled - so back-pressure lands on every phase
    // of the pipeline, with clean stretches in between.
    always @(posedge clk)
    begin
        if (stall_span == 0) begin
            stall_span <= $urandom_range(20, 80);
            stall_mode <= $urandom_range(0, 3);
        end
        else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: count cycles in which no channel moves anything, and give up
    // once the count reaches the limit.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Clip an integer into the sample range.
    function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
        int c;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > 1023) begin
            c = 1023;
        end
        return SAMPLE_W'(c);
    endfunction

    // Draw a sample: uniform, near a ladder threshold, near a raw step edge,
    // at the range ends, or a small wander from the previous sample (which
    // gives the peak hold something realistic to chase).
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 5))
            0:       s = SAMPLE_W'($urandom_range(0, 1023));
            1:       s = clip_sample(int'(LADDER[$urandom_range(0, 9)]) +
                                     $urandom_range(0, 2) - 1);
            2:       s = clip_sample(cur_offset + RAW_STEP * $urandom_range(0, 11) +
                                     $urandom_range(0, 2) - 1);
            3:       s = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(1021, 1023))
                                              : SAMPLE_W'($urandom_range(0, 2));
            default: s = clip_sample(prev_sample + $urandom_range(0, 60) - 30);
        endcase
        prev_sample = s;
        return s;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic lvl);
        in_valid   <= 1'b1;
        sample     <= s;
        level_mode <= lvl;
        do @(posedge clk); while (!in_ready);
    endtask

    // Close a burst when its count runs out, usually with a gap after it.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    endtask

    task automatic feed(input logic [SAMPLE_W-1:0] s, input logic lvl);
        push_sample(s, lvl);
        pace();
    endtask

    // Drop valid and hold off until every reading has come back, then let
    // the two pipeline stages settle before anything else happens.
    task automatic await_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then drop valid.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_meter(input logic [CFG_DATA_W-1:0] hold_data,
                             input logic [CFG_DATA_W-1:0] offset_data);
        write_reg(CFG_HOLD_SAMPLES, hold_data);
        write_reg(CFG_RAW_OFFSET, offset_data);
        cur_offset = offset_data;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] hold_data;
        logic [CFG_DATA_W-1:0] offset_data;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (hold 100, offset 523). Empty peak first, then a
        // full-scale sample that becomes the peak and is held while the
        // input drops away; raw mode below, at and around the offset, and full
        // scale, which gives a quotient of exactly ten.
        feed(10'd0, 1'b1);
        feed(10'd1023, 1'b1);
        feed(10'd0, 1'b1);
        feed(10'd0, 1'b0);
        feed(10'd522, 1'b0);
        feed(10'd523, 1'b0);
        feed(10'd572, 1'b0);
        feed(10'd573, 1'b0);
        feed(10'd1023, 1'b0);
        await_quiet();

        // Zero hold makes the peak follow the sample, so the ladder can be
        // walked directly: just under and on the first and last thresholds.
        // Offset zero gives the widest raw range. Upper data bits set on
        // the hold write must be dropped; spare indexes must do nothing.
        set_meter(10'h300, 10'd0);
        write_reg(CFG_SPARE_LOW, 10'h3FF);
        write_reg(CFG_SPARE_HIGH, 10'h155);
        feed(10'd614, 1'b1);
        feed(10'd615, 1'b1);
        feed(10'd887, 1'b1);
        feed(10'd888, 1'b1);
        feed(10'd1023, 1'b1);
        feed(10'd0, 1'b0);
        feed(10'd49, 1'b0);
        feed(10'd50, 1'b0);
        feed(10'd499, 1'b0);
        feed(10'd500, 1'b0);
        feed(10'd1023, 1'b0);

        // Random phases: extremes of both registers first, then random
        // settings with mostly short holds so the peak keeps moving. Each
        // phase starts from a fully drained pipeline.
        for (int ph = 0; ph < 8; ph++) begin
            await_quiet();
            case (ph)
                0:       begin hold_data = 10'd255;  offset_data = 10'd1023; end
                1:       begin hold_data = 10'd1;    offset_data = 10'd0;    end
                2:       begin hold_data = 10'h3FF;  offset_data = 10'd1;    end
                3:       begin hold_data = 10'd0;    offset_data = 10'd523;  end
                default: begin
                    hold_data   = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 12))
                                                       : CFG_DATA_W'($urandom_range(0, 1023));
                    offset_data = CFG_DATA_W'($urandom_range(0, 1023));
                end
            endcase
            set_meter(hold_data, offset_data);
            if (ph % 3 == 2) begin
                write_reg((ph % 2 != 0) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                          CFG_DATA_W'($urandom_range(0, 1023)));
            end
            for (int n = 0; n < 68; n++) begin
                feed(pick_sample(), $urandom_range(0, 1) != 0);
            end
        end

        // Drain everything still in flight, allow for the pipeline, judge.
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        if (meter_errors == 0 && readings_pending == 0) begin
            $display("DONE: 0 errors");
        end
        else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* peak_hold_level_bar_meter_unit.f */
sv/phbm_pkg.sv
sv/phbm_peak_track.sv
sv/phbm_bar_map.sv
sv/peak_hold_level_bar_meter_unit.sv
test/peak_hold_meter_checker.sv
test/peak_hold_level_bar_meter_unit_test.sv
